[src/obl_pkg.sv]
// Shared constants, codes and types for the order book level queues.
package obl_pkg;

  localparam int POOL_DEPTH      = 1024;
  localparam int LEVELS_PER_SIDE = 64;
  localparam int LEVELS          = 2 * LEVELS_PER_SIDE;

  localparam int SLOT_W  = $clog2(POOL_DEPTH);
  localparam int CNT_W   = SLOT_W + 1;
  localparam int LVL_W   = $clog2(LEVELS_PER_SIDE);
  localparam int LIDX_W  = LVL_W + 1;
  localparam int LIQ_W   = 42;
  localparam int SLOTF_W = 10;

  localparam logic [1:0] CMD_ADD     = 2'd0;
  localparam logic [1:0] CMD_CANCEL  = 2'd1;
  localparam logic [1:0] CMD_CONSUME = 2'd2;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_POOL_FULL   = 3'd1;
  localparam logic [2:0] ST_LEVEL_FULL  = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND   = 3'd3;
  localparam logic [2:0] ST_SLOT_UNUSED = 3'd4;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [31:0]        client_id;
    logic               side;
    logic [31:0]        price;
    logic [31:0]        quantity;
    logic [SLOTF_W-1:0] slot_in;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic [SLOTF_W-1:0] slot_out;
    logic [31:0]        removed_id;
    logic [31:0]        removed_qty;
    logic [LIQ_W-1:0]   level_liquidity;
    logic               level_emptied;
  } out_item_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LATCH,
    OP_ERR,
    OP_KEYLD,
    OP_CMP,
    OP_ENC,
    OP_SLRD,
    OP_AWR1,
    OP_AWR2,
    OP_UWR,
    OP_LOAD
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] err;
  } ctl_t;

  typedef struct packed {
    logic pool_empty;
    logic slot_ok;
    logic slot_used;
    logic found;
    logic free_ok;
    logic out_busy;
  } stat_t;

endpackage

[src/obl_ctrl.sv]
// Command sequencer for the order book level queues.
module obl_ctrl import obl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_cmd,
  output logic       in_stall,
  input  stat_t      stat,
  output ctl_t       ctl
);

  typedef enum logic [3:0] {
    S_IDLE, S_XRD, S_CMP, S_ENC, S_CSL, S_AWR1, S_AWR2, S_UWR, S_RES
  } state_t;

  state_t     state_r, state_nxt;
  logic [1:0] cmd_r, cmd_nxt;

  always_comb begin
    ctl       = '{op: OP_NONE, err: ST_OK};
    state_nxt = state_r;
    cmd_nxt   = cmd_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctl.op  = OP_LATCH;
          cmd_nxt = in_cmd;
          case (in_cmd)
            CMD_ADD: begin
              if (stat.pool_empty) begin
                ctl.err   = ST_POOL_FULL;
                state_nxt = S_RES;
              end else begin
                state_nxt = S_CMP;
              end
            end
            CMD_CONSUME: state_nxt = S_CMP;
            CMD_CANCEL: begin
              if (stat.slot_ok) begin
                state_nxt = S_XRD;
              end else begin
                ctl.err   = ST_SLOT_UNUSED;
                state_nxt = S_RES;
              end
            end
            default: state_nxt = S_RES;
          endcase
        end
      end
      S_XRD: begin
        if (stat.slot_used) begin
          ctl.op    = OP_KEYLD;
          state_nxt = S_CMP;
        end else begin
          ctl.op    = OP_ERR;
          ctl.err   = ST_SLOT_UNUSED;
          state_nxt = S_RES;
        end
      end
      S_CMP: begin
        ctl.op    = OP_CMP;
        state_nxt = S_ENC;
      end
      S_ENC: begin
        if (cmd_r == CMD_ADD) begin
          if (stat.found || stat.free_ok) begin
            ctl.op    = OP_ENC;
            state_nxt = S_AWR1;
          end else begin
            ctl.op    = OP_ERR;
            ctl.err   = ST_LEVEL_FULL;
            state_nxt = S_RES;
          end
        end else if (stat.found) begin
          ctl.op    = OP_ENC;
          state_nxt = (cmd_r == CMD_CONSUME) ? S_CSL : S_UWR;
        end else begin
          ctl.op    = OP_ERR;
          ctl.err   = ST_NOT_FOUND;
          state_nxt = S_RES;
        end
      end
      S_CSL: begin
        ctl.op    = OP_SLRD;
        state_nxt = S_UWR;
      end
      S_AWR1: begin
        ctl.op    = OP_AWR1;
        state_nxt = S_AWR2;
      end
      S_AWR2: begin
        ctl.op    = OP_AWR2;
        state_nxt = S_RES;
      end
      S_UWR: begin
        ctl.op    = OP_UWR;
        state_nxt = S_RES;
      end
      S_RES: begin
        if (!stat.out_busy) begin
          ctl.op    = OP_LOAD;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cmd_r   <= CMD_ADD;
    end else begin
      state_r <= state_nxt;
      cmd_r   <= cmd_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

[src/obl_dpath.sv]
// Datapath: slot pool memories, free stack, level table and result registers.
module obl_dpath import obl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  ctl_t      ctl,
  input  in_item_t  in_data,
  input  logic      out_stall,
  output stat_t     stat,
  output logic      out_valid,
  output out_item_t out_data
);

  typedef struct packed {
    logic [SLOT_W-1:0] head;
    logic [SLOT_W-1:0] tail;
    logic [LIQ_W-1:0]  liq;
  } lvl_t;

  typedef struct packed {
    logic        side;
    logic [31:0] price;
    logic [31:0] qty;
    logic [31:0] id;
  } sdata_t;

  typedef struct packed {
    logic              vld;
    logic [SLOT_W-1:0] ptr;
  } link_t;

  // memories
  lvl_t              lvl_mem  [LEVELS];
  sdata_t            sd_mem   [POOL_DEPTH];
  link_t             prv_mem  [POOL_DEPTH];
  link_t             nxt_mem  [POOL_DEPTH];
  logic              used_mem [POOL_DEPTH];
  logic [SLOT_W-1:0] stk_mem  [POOL_DEPTH];

  lvl_t              lv_rd_r;
  sdata_t            sd_rd_r;
  link_t             prv_rd_r, nxt_rd_r;
  logic              used_rd_r;
  logic [SLOT_W-1:0] stk_rd_r;

  // level keys (compared in parallel) and control registers
  logic [31:0]       price_r [LEVELS];
  logic [LEVELS-1:0] valid_r, match_r, match_nxt;
  logic [CNT_W-1:0]  fc_r, hwm_r;
  logic              out_valid_r;
  out_item_t         out_r, res_r;
  in_item_t          in_r;
  logic              key_side_r;
  logic [31:0]       key_price_r;
  logic [LIDX_W-1:0] idx_r;
  logic              new_r;
  logic [SLOT_W-1:0] s_r;

  function automatic logic [LVL_W-1:0] lowest(input logic [LEVELS_PER_SIDE-1:0] v);
    logic [LVL_W-1:0] r;
    r = '0;
    for (int i = LEVELS_PER_SIDE - 1; i >= 0; i--) begin
      if (v[i]) r = LVL_W'(i);
    end
    return r;
  endfunction

  logic [LEVELS_PER_SIDE-1:0] hit_vec, free_vec;
  logic                       found, free_ok, fresh;
  logic [LIDX_W-1:0]          enc_idx;

  always_comb begin
    for (int i = 0; i < LEVELS; i++) begin
      match_nxt[i] = valid_r[i] && (price_r[i] == key_price_r) &&
                     ((i >= LEVELS_PER_SIDE) == key_side_r);
    end
  end

  assign hit_vec  = key_side_r ? match_r[LEVELS-1 -: LEVELS_PER_SIDE]
                               : match_r[LEVELS_PER_SIDE-1:0];
  assign free_vec = key_side_r ? ~valid_r[LEVELS-1 -: LEVELS_PER_SIDE]
                               : ~valid_r[LEVELS_PER_SIDE-1:0];
  assign found    = |hit_vec;
  assign free_ok  = |free_vec;
  assign enc_idx  = {key_side_r, lowest(found ? hit_vec : free_vec)};

  // slots below the high-water mark have all been handed out at least once
  assign fresh = ((fc_r + hwm_r) == CNT_W'(POOL_DEPTH));

  assign stat.pool_empty = (fc_r == '0);
  assign stat.slot_ok    = (CNT_W'(in_data.slot_in) < hwm_r);
  assign stat.slot_used  = used_rd_r;
  assign stat.found      = found;
  assign stat.free_ok    = free_ok;
  assign stat.out_busy   = out_valid_r && out_stall;

  // add
  logic [SLOT_W-1:0] a_s;
  logic [LIQ_W-1:0]  a_base, a_liq;
  logic [LIQ_W:0]    a_sum;
  assign a_s    = fresh ? hwm_r[SLOT_W-1:0] : stk_rd_r;
  assign a_base = new_r ? '0 : lv_rd_r.liq;
  assign a_sum  = {1'b0, a_base} + (LIQ_W+1)'(in_r.quantity);
  assign a_liq  = a_sum[LIQ_W] ? {LIQ_W{1'b1}} : a_sum[LIQ_W-1:0];

  // unlink
  logic [SLOT_W-1:0] u_s;
  logic              u_empty;
  logic [LIQ_W-1:0]  u_liq;
  assign u_s     = (in_r.cmd == CMD_CANCEL) ? in_r.slot_in[SLOT_W-1:0] : lv_rd_r.head;
  assign u_empty = !prv_rd_r.vld && !nxt_rd_r.vld;
  assign u_liq   = (lv_rd_r.liq > LIQ_W'(sd_rd_r.qty)) ?
                   lv_rd_r.liq - LIQ_W'(sd_rd_r.qty) : '0;

  // memory port selection
  logic              sl_re;
  logic [SLOT_W-1:0] sl_ra;
  logic              lv_we, sd_we, prv_we, nxt_we, used_we, used_wd, stk_we;
  lvl_t              lv_wd;
  sdata_t            sd_wd;
  link_t             prv_wd, nxt_wd;
  logic [SLOT_W-1:0] sd_wa, prv_wa, nxt_wa, used_wa, stk_wa, stk_wd;

  always_comb begin
    sl_re   = (ctl.op == OP_LATCH) || (ctl.op == OP_SLRD);
    sl_ra   = (ctl.op == OP_SLRD) ? lv_rd_r.head : in_data.slot_in[SLOT_W-1:0];
    lv_we   = 1'b0;
    lv_wd   = lv_rd_r;
    sd_we   = 1'b0;
    sd_wa   = a_s;
    sd_wd   = '{side: in_r.side, price: in_r.price, qty: in_r.quantity, id: in_r.client_id};
    prv_we  = 1'b0;
    prv_wa  = a_s;
    prv_wd  = '{vld: !new_r, ptr: lv_rd_r.tail};
    nxt_we  = 1'b0;
    nxt_wa  = a_s;
    nxt_wd  = '0;
    used_we = 1'b0;
    used_wa = a_s;
    used_wd = 1'b1;
    stk_we  = 1'b0;
    stk_wa  = fc_r[SLOT_W-1:0];
    stk_wd  = u_s;
    case (ctl.op)
      OP_AWR1: begin
        lv_we   = 1'b1;
        lv_wd   = '{head: new_r ? a_s : lv_rd_r.head, tail: a_s, liq: a_liq};
        sd_we   = 1'b1;
        prv_we  = 1'b1;
        nxt_we  = 1'b1;
        used_we = 1'b1;
      end
      OP_AWR2: begin
        nxt_we = !new_r;
        nxt_wa = lv_rd_r.tail;
        nxt_wd = '{vld: 1'b1, ptr: s_r};
      end
      OP_UWR: begin
        lv_we   = !u_empty;
        lv_wd   = '{head: prv_rd_r.vld ? lv_rd_r.head : nxt_rd_r.ptr,
                    tail: nxt_rd_r.vld ? lv_rd_r.tail : prv_rd_r.ptr,
                    liq:  u_liq};
        prv_we  = nxt_rd_r.vld;
        prv_wa  = nxt_rd_r.ptr;
        prv_wd  = prv_rd_r;
        nxt_we  = prv_rd_r.vld;
        nxt_wa  = prv_rd_r.ptr;
        nxt_wd  = nxt_rd_r;
        used_we = 1'b1;
        used_wa = u_s;
        used_wd = 1'b0;
        stk_we  = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (lv_we) lvl_mem[idx_r] <= lv_wd;
    if (sd_we) sd_mem[sd_wa] <= sd_wd;
    if (prv_we) prv_mem[prv_wa] <= prv_wd;
    if (nxt_we) nxt_mem[nxt_wa] <= nxt_wd;
    if (used_we) used_mem[used_wa] <= used_wd;
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    if (ctl.op == OP_ENC) begin
      lv_rd_r  <= lvl_mem[enc_idx];
      stk_rd_r <= stk_mem[SLOT_W'(fc_r - 1'b1)];
    end
    if (sl_re) begin
      sd_rd_r   <= sd_mem[sl_ra];
      prv_rd_r  <= prv_mem[sl_ra];
      nxt_rd_r  <= nxt_mem[sl_ra];
      used_rd_r <= used_mem[sl_ra];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= '0;
      fc_r        <= CNT_W'(POOL_DEPTH);
      hwm_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctl.op == OP_AWR1) begin
        valid_r[idx_r] <= 1'b1;
        fc_r           <= fc_r - 1'b1;
        if (fresh) hwm_r <= hwm_r + 1'b1;
      end
      if (ctl.op == OP_UWR) begin
        fc_r <= fc_r + 1'b1;
        if (u_empty) valid_r[idx_r] <= 1'b0;
      end
      if (ctl.op == OP_LOAD) out_valid_r <= 1'b1;
      else if (!out_stall)   out_valid_r <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_LATCH: begin
        in_r        <= in_data;
        key_side_r  <= in_data.side;
        key_price_r <= in_data.price;
        res_r       <= '{status: ctl.err, default: '0};
      end
      OP_ERR: res_r <= '{status: ctl.err, default: '0};
      OP_KEYLD: begin
        key_side_r  <= sd_rd_r.side;
        key_price_r <= sd_rd_r.price;
      end
      OP_CMP: match_r <= match_nxt;
      OP_ENC: begin
        idx_r <= enc_idx;
        new_r <= !found;
      end
      OP_AWR1: begin
        price_r[idx_r]        <= in_r.price;
        s_r                   <= a_s;
        res_r.status          <= ST_OK;
        res_r.slot_out        <= SLOTF_W'(a_s);
        res_r.removed_id      <= '0;
        res_r.removed_qty     <= '0;
        res_r.level_liquidity <= a_liq;
        res_r.level_emptied   <= 1'b0;
      end
      OP_UWR: begin
        res_r.status          <= ST_OK;
        res_r.slot_out        <= SLOTF_W'(u_s);
        res_r.removed_id      <= sd_rd_r.id;
        res_r.removed_qty     <= sd_rd_r.qty;
        res_r.level_liquidity <= u_empty ? '0 : u_liq;
        res_r.level_emptied   <= u_empty;
      end
      OP_LOAD: out_r <= res_r;
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[src/order_book_level_queues_core.sv]
// Top level of the order book level queues: sequencer, datapath, checks.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------
//   in_     | input     | in_valid / in_stall  | in_item_t
//   out_    | output    | out_valid / out_stall| out_item_t
//
// A command runs these steps: for a cancel, slot read and key load; parallel
// price compare; registered encode with level read; for a consume, a read of
// the head slot; one write, or two for an add; load. The next item is taken
// only back in idle after the load. Errors at acceptance go straight to the
// load, an unused slot after the slot read, a missing level or full table after encode.
// Reset (rst_n low, synchronous) empties the level table and refills the free
// pool through a high-water mark; no clearing pass is needed.
// in_stall is high from acceptance until the result is loaded. A result held
// by out_stall does not block acceptance; the next item waits only at its load.
module order_book_level_queues_core import obl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  ctl_t  ctl;
  stat_t stat;

  obl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_data.cmd),
    .in_stall (in_stall),
    .stat     (stat),
    .ctl      (ctl)
  );

  obl_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_data   (in_data),
    .out_stall (out_stall),
    .stat      (stat),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  // one item at a time: an accepted item blocks the next
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted twice in a row");

  // error results carry nothing but the status
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |->
      out_data.slot_out == '0 && out_data.removed_id == '0 &&
      out_data.removed_qty == '0 && out_data.level_liquidity == '0 &&
      !out_data.level_emptied)
    else $error("error result with nonzero fields");

  // a removed level reports no liquidity
  a_emptied_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.level_emptied |-> out_data.level_liquidity == '0)
    else $error("emptied level with liquidity");

endmodule

[tb/sv/tb.sv]
// Self-checking testbench for order_book_level_queues_core.
module tb;
  import obl_pkg::*;

  localparam logic [63:0] LIQ_MAX = 64'h3FF_FFFF_FFFF;
  localparam int DOG_LIMIT = 5000;

  typedef struct {
    bit          valid;
    logic [31:0] price;
    int          head;
    int          tail;
    logic [63:0] liq;
  } book_level_t;

  typedef struct {
    in_item_t  it;
    bit        typed;
    out_item_t res;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  order_book_level_queues_core DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Book mirror
  logic [31:0] ord_id [POOL_DEPTH];
  logic [31:0] ord_qty [POOL_DEPTH];
  logic        ord_side [POOL_DEPTH];
  logic [31:0] ord_price [POOL_DEPTH];
  bit          ord_used [POOL_DEPTH];
  bit          has_prv [POOL_DEPTH];
  bit          has_nxt [POOL_DEPTH];
  int          prv [POOL_DEPTH];
  int          nxt [POOL_DEPTH];
  int          free_stk [POOL_DEPTH];
  int          free_cnt;
  book_level_t lvl [LEVELS];

  out_item_t pending_results[$];
  int        mismatches = 0;
  int        quiet_cycles;
  bit        idle_on;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic void book_reset();
    for (int i = 0; i < POOL_DEPTH; i++) begin
      ord_used[i] = 0;
      has_prv[i]  = 0;
      has_nxt[i]  = 0;
      prv[i]      = 0;
      nxt[i]      = 0;
      free_stk[i] = POOL_DEPTH - 1 - i;
    end
    free_cnt = POOL_DEPTH;
    for (int k = 0; k < LEVELS; k++) lvl[k] = '{0, 32'd0, 0, 0, 64'd0};
  endfunction

  function automatic int find_lvl(logic side, logic [31:0] price);
    int base;
    base = side * LEVELS_PER_SIDE;
    for (int k = 0; k < LEVELS_PER_SIDE; k++)
      if (lvl[base + k].valid && lvl[base + k].price == price) return base + k;
    return -1;
  endfunction

  function automatic int open_lvl(logic side);
    int base;
    base = side * LEVELS_PER_SIDE;
    for (int k = 0; k < LEVELS_PER_SIDE; k++)
      if (!lvl[base + k].valid) return base + k;
    return -1;
  endfunction

  function automatic out_item_t err_res(logic [2:0] st);
    out_item_t r;
    r = '0;
    r.status = st;
    return r;
  endfunction

  // Remove slot s from the FIFO of level li and return it to the free stack.
  function automatic out_item_t take_order(int li, int s);
    out_item_t r;
    bit emptied;
    r = '0;
    emptied = 0;
    if (!has_prv[s] && !has_nxt[s]) begin
      lvl[li].valid = 0;
      lvl[li].liq = 0;
      emptied = 1;
    end else begin
      lvl[li].liq = (lvl[li].liq > ord_qty[s]) ? lvl[li].liq - ord_qty[s] : 64'd0;
      if (has_nxt[s]) begin
        has_prv[nxt[s]] = has_prv[s];
        prv[nxt[s]] = prv[s];
      end else lvl[li].tail = prv[s];
      if (has_prv[s]) begin
        has_nxt[prv[s]] = has_nxt[s];
        nxt[prv[s]] = nxt[s];
      end else lvl[li].head = nxt[s];
    end
    has_prv[s] = 0;
    has_nxt[s] = 0;
    ord_used[s] = 0;
    if (free_cnt < POOL_DEPTH) begin
      free_stk[free_cnt] = s;
      free_cnt++;
    end
    r.slot_out        = SLOTF_W'(s);
    r.removed_id      = ord_id[s];
    r.removed_qty     = ord_qty[s];
    r.level_liquidity = emptied ? '0 : lvl[li].liq[LIQ_W-1:0];
    r.level_emptied   = emptied;
    return r;
  endfunction

  function automatic out_item_t book_step(in_item_t it);
    out_item_t r;
    int li;
    int s;
    r = '0;
    case (it.cmd)
      CMD_ADD: begin
        if (free_cnt == 0) return err_res(ST_POOL_FULL);
        li = find_lvl(it.side, it.price);
        if (li < 0) begin
          li = open_lvl(it.side);
          if (li < 0) return err_res(ST_LEVEL_FULL);
          lvl[li] = '{1, it.price, POOL_DEPTH, 0, 64'd0};
        end
        free_cnt--;
        s = free_stk[free_cnt];
        ord_id[s] = it.client_id;
        ord_qty[s] = it.quantity;
        ord_side[s] = it.side;
        ord_price[s] = it.price;
        ord_used[s] = 1;
        has_nxt[s] = 0;
        nxt[s] = 0;
        if (lvl[li].head >= POOL_DEPTH) begin
          lvl[li].head = s;
          has_prv[s] = 0;
          prv[s] = 0;
        end else begin
          has_nxt[lvl[li].tail] = 1;
          nxt[lvl[li].tail] = s;
          has_prv[s] = 1;
          prv[s] = lvl[li].tail;
        end
        lvl[li].tail = s;
        lvl[li].liq = (LIQ_MAX - lvl[li].liq < it.quantity) ? LIQ_MAX
                                                             : lvl[li].liq + it.quantity;
        r.slot_out = SLOTF_W'(s);
        r.level_liquidity = lvl[li].liq[LIQ_W-1:0];
      end
      CMD_CANCEL: begin
        s = it.slot_in;
        if (s >= POOL_DEPTH || !ord_used[s]) return err_res(ST_SLOT_UNUSED);
        li = find_lvl(ord_side[s], ord_price[s]);
        if (li < 0) return err_res(ST_NOT_FOUND);
        r = take_order(li, s);
      end
      CMD_CONSUME: begin
        li = find_lvl(it.side, it.price);
        if (li < 0 || lvl[li].head >= POOL_DEPTH) return err_res(ST_NOT_FOUND);
        r = take_order(li, lvl[li].head);
      end
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic in_item_t mk(logic [1:0] cmd, logic [31:0] id, logic side,
                                  logic [31:0] price, logic [31:0] qty, int slot);
    in_item_t it;
    it.cmd = cmd;
    it.client_id = id;
    it.side = side;
    it.price = price;
    it.quantity = qty;
    it.slot_in = SLOTF_W'(slot);
    return it;
  endfunction

  function automatic out_item_t mkr(logic [2:0] st, int slot, logic [31:0] id,
                                    logic [31:0] qty, logic [63:0] liq, bit emp);
    out_item_t r;
    r.status = st;
    r.slot_out = SLOTF_W'(slot);
    r.removed_id = id;
    r.removed_qty = qty;
    r.level_liquidity = liq[LIQ_W-1:0];
    r.level_emptied = emp;
    return r;
  endfunction

  // Pick a resting order at random, -1 if the book is empty.
  function automatic int some_live_slot();
    int start;
    start = $urandom_range(0, POOL_DEPTH - 1);
    for (int i = 0; i < POOL_DEPTH; i++)
      if (ord_used[(start + i) % POOL_DEPTH]) return (start + i) % POOL_DEPTH;
    return -1;
  endfunction

  // Mostly a small price set so levels are shared and the table can fill.
  function automatic logic [31:0] pick_price();
    return ($urandom_range(0, 99) < 70) ? 32'($urandom_range(0, 79)) : $urandom;
  endfunction

  function automatic in_item_t rand_item(int p_add, int p_cancel, int p_cons);
    in_item_t it;
    int roll;
    int s;
    it = mk(CMD_ADD, $urandom, 1'($urandom_range(0, 1)), pick_price(), $urandom,
            $urandom_range(0, POOL_DEPTH - 1));
    roll = $urandom_range(0, 99);
    if (roll < p_add) it.cmd = CMD_ADD;
    else if (roll < p_add + p_cancel) begin
      it.cmd = CMD_CANCEL;
      s = some_live_slot();
      if (s >= 0 && $urandom_range(0, 9) < 8) it.slot_in = SLOTF_W'(s);
    end else if (roll < p_add + p_cancel + p_cons) begin
      it.cmd = CMD_CONSUME;
      s = some_live_slot();
      if (s >= 0 && $urandom_range(0, 9) < 8) begin
        it.side = ord_side[s];
        it.price = ord_price[s];
      end
    end else it.cmd = 2'd3;
    return it;
  endfunction

  // Offer one item, wait for acceptance, then queue what it must produce.
  task automatic send_item(in_item_t it, bit typed, out_item_t typed_res);
    out_item_t r;
    if (idle_on && $urandom_range(0, 99) < 13) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = book_step(it);
    pending_results.push_back(typed ? typed_res : r);
  endtask

  // Result side: check on acceptance, stall at random.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result %p", out_data);
        end else begin
          out_item_t e;
          e = pending_results.pop_front();
          if (e !== out_data) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch: expected %p got %p", e, out_data);
          end
        end
      end
      out_stall <= idle_on && ($urandom_range(0, 99) < 13);
    end
  end

  // Watchdog on cycles with no handshake on either channel.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= DOG_LIMIT) begin
      $display("order_book_level_queues_core test failed");
      $finish;
    end
  end

  initial begin
    dir_row_t rows[$];
    out_item_t none;
    int n;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_stall = 1'b0;
    idle_on = 1;
    none = '0;
    book_reset();

    // Directed table: typed rows are the obvious answers, others use the mirror.
    rows.push_back('{mk(CMD_CONSUME, 0, 0, 5, 0, 0), 1, mkr(ST_NOT_FOUND, 0, 0, 0, 0, 0)});
    rows.push_back('{mk(CMD_CANCEL, 0, 0, 0, 0, 0), 1, mkr(ST_SLOT_UNUSED, 0, 0, 0, 0, 0)});
    rows.push_back('{mk(CMD_CANCEL, '1, 1, '1, '1, 1023), 1,
                     mkr(ST_SLOT_UNUSED, 0, 0, 0, 0, 0)});
    rows.push_back('{mk(2'd3, '1, 1, '1, '1, 1023), 1, mkr(ST_OK, 0, 0, 0, 0, 0)});
    rows.push_back('{mk(CMD_ADD, '1, 0, '1, '1, 0), 1,
                     mkr(ST_OK, 0, 0, 0, 64'hFFFF_FFFF, 0)});
    rows.push_back('{mk(CMD_ADD, 32'h1234, 0, '1, '1, 0), 1,
                     mkr(ST_OK, 1, 0, 0, 64'h1_FFFF_FFFE, 0)});
    rows.push_back('{mk(CMD_ADD, 0, 1, 0, 0, 0), 1, mkr(ST_OK, 2, 0, 0, 0, 0)});
    rows.push_back('{mk(CMD_CONSUME, 0, 0, '1, 0, 0), 1,
                     mkr(ST_OK, 0, '1, '1, 64'hFFFF_FFFF, 0)});
    rows.push_back('{mk(CMD_CANCEL, 0, 0, 0, 0, 1), 1,
                     mkr(ST_OK, 1, 32'h1234, '1, 0, 1)});
    rows.push_back('{mk(CMD_CANCEL, 0, 0, 0, 0, 1), 1, mkr(ST_SLOT_UNUSED, 0, 0, 0, 0, 0)});
    // three orders at one side 1 level: cancel the middle, add a fourth, cancel the head, consume the rest
    rows.push_back('{mk(CMD_ADD, 11, 1, 7, 100, 0), 0, none});
    rows.push_back('{mk(CMD_ADD, 12, 1, 7, 200, 0), 0, none});
    rows.push_back('{mk(CMD_ADD, 13, 1, 7, 300, 0), 0, none});
    rows.push_back('{mk(CMD_CANCEL, 0, 0, 0, 0, 0), 0, none});
    rows.push_back('{mk(CMD_ADD, 14, 1, 7, 400, 0), 0, none});
    rows.push_back('{mk(CMD_CANCEL, 0, 0, 0, 0, 1), 0, none});
    rows.push_back('{mk(CMD_CONSUME, 0, 1, 7, 0, 0), 0, none});
    rows.push_back('{mk(CMD_CONSUME, 0, 1, 7, 0, 0), 0, none});
    rows.push_back('{mk(CMD_CONSUME, 0, 1, 7, 0, 0), 0, none});
    rows.push_back('{mk(CMD_CONSUME, 0, 1, 0, 0, 0), 0, none});

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_item(rows[i].it, rows[i].typed, rows[i].res);

    // Mixed traffic, add heavy.
    repeat (50) send_item(rand_item(50, 20, 25), 0, none);

    // Let the book settle before the pool is filled.
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);

    // Back to back adds, mostly into existing levels, until the pool runs dry;
    // then three more adds that find the pool full.
    idle_on = 0;
    n = 0;
    while (free_cnt > 0 || n < 3) begin
      in_item_t it;
      int s;
      it = mk(CMD_ADD, $urandom, 1'($urandom_range(0, 1)), pick_price(), $urandom, 0);
      s = some_live_slot();
      if (s >= 0 && $urandom_range(0, 99) < 85) begin
        it.side = ord_side[s];
        it.price = ord_price[s];
      end
      if (free_cnt == 0) n++;
      send_item(it, 0, none);
    end
    idle_on = 1;

    // Drain with cancels and consumes.
    repeat (50) send_item(rand_item(15, 40, 40), 0, none);

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("order_book_level_queues_core test passed");
    else $display("order_book_level_queues_core test failed");
    $finish;
  end

endmodule

[filelist.f]
src/obl_pkg.sv
src/obl_ctrl.sv
src/obl_dpath.sv
src/order_book_level_queues_core.sv
tb/sv/tb.sv
